FILE: src/esrb_pkg.sv
// Shared types, codes and register-field helpers for the socket register bank.
// Used by the controller, the datapath and the top level.
package esrb_pkg;

  // default sizes
  localparam int DefStoreDepth = 65536;
  localparam int DefSockets    = 4;
  localparam int DefRingBytes  = 2048;
  localparam int MaxSockets    = 4;

  // item command codes
  localparam logic [2:0] CMD_BUS_RD  = 3'd0;
  localparam logic [2:0] CMD_BUS_WR  = 3'd1;
  localparam logic [2:0] CMD_CONN_OK = 3'd2;
  localparam logic [2:0] CMD_CONN_NG = 3'd3;
  localparam logic [2:0] CMD_RX_BYTE = 3'd4;
  localparam logic [2:0] CMD_PEER_CL = 3'd5;

  // bus ports
  localparam logic [1:0] PORT_MODE = 2'd0;
  localparam logic [1:0] PORT_ADDH = 2'd1;
  localparam logic [1:0] PORT_ADDL = 2'd2;
  localparam logic [1:0] PORT_DATA = 2'd3;

  // socket commands
  localparam logic [7:0] SC_OPEN    = 8'h01;
  localparam logic [7:0] SC_CONNECT = 8'h04;
  localparam logic [7:0] SC_DISCON  = 8'h08;
  localparam logic [7:0] SC_CLOSE   = 8'h10;
  localparam logic [7:0] SC_SEND    = 8'h20;
  localparam logic [7:0] SC_RECV    = 8'h40;

  // socket status codes
  localparam logic [7:0] ST_CLOSED    = 8'h00;
  localparam logic [7:0] ST_INIT      = 8'h13;
  localparam logic [7:0] ST_SYNSENT   = 8'h15;
  localparam logic [7:0] ST_EST       = 8'h17;
  localparam logic [7:0] ST_CLOSEWAIT = 8'h1C;
  localparam logic [7:0] ST_UDP       = 8'h22;

  localparam logic [7:0] MODE_RESET  = 8'h03;
  localparam logic [15:0] RING_BASE  = 16'h6000;
  localparam logic [5:0] SOCK_REGION = 6'b000001;

  // socket register offsets
  localparam logic [7:0] OFS_MODE   = 8'h00;
  localparam logic [7:0] OFS_CMD    = 8'h01;
  localparam logic [7:0] OFS_STAT   = 8'h03;
  localparam logic [7:0] OFS_TXFR_H = 8'h20;
  localparam logic [7:0] OFS_TXFR_L = 8'h21;
  localparam logic [7:0] OFS_TXRD_H = 8'h22;
  localparam logic [7:0] OFS_TXRD_L = 8'h23;
  localparam logic [7:0] OFS_TXWR_H = 8'h24;
  localparam logic [7:0] OFS_TXWR_L = 8'h25;
  localparam logic [7:0] OFS_RXSZ_H = 8'h26;
  localparam logic [7:0] OFS_RXSZ_L = 8'h27;
  localparam logic [7:0] OFS_RXRD_H = 8'h28;
  localparam logic [7:0] OFS_RXRD_L = 8'h29;

  typedef struct packed {
    logic [7:0]  mode;
    logic [7:0]  cmd;
    logic [7:0]  stat;
    logic [15:0] txfree;
    logic [15:0] txrd;
    logic [15:0] txwr;
    logic [15:0] rxsize;
    logic [15:0] rxrd;
  } sock_regs_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic capture;
    logic clear_step;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_read;
    logic clr_pend;
    logic clear_done;
  } ctrl_stat_t;

  // offset held in socket flops rather than the store
  function automatic logic sock_hit(input logic [7:0] ofs);
    logic hit;
    case (ofs)
      OFS_MODE, OFS_CMD, OFS_STAT, OFS_TXFR_H, OFS_TXFR_L, OFS_TXRD_H, OFS_TXRD_L,
      OFS_TXWR_H, OFS_TXWR_L, OFS_RXSZ_H, OFS_RXSZ_L, OFS_RXRD_H, OFS_RXRD_L: hit = 1'b1;
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

  function automatic logic [7:0] sock_rd(input sock_regs_t r, input logic [7:0] ofs);
    logic [7:0] v;
    case (ofs)
      OFS_MODE:   v = r.mode;
      OFS_CMD:    v = r.cmd;
      OFS_STAT:   v = r.stat;
      OFS_TXFR_H: v = r.txfree[15:8];
      OFS_TXFR_L: v = r.txfree[7:0];
      OFS_TXRD_H: v = r.txrd[15:8];
      OFS_TXRD_L: v = r.txrd[7:0];
      OFS_TXWR_H: v = r.txwr[15:8];
      OFS_TXWR_L: v = r.txwr[7:0];
      OFS_RXSZ_H: v = r.rxsize[15:8];
      OFS_RXSZ_L: v = r.rxsize[7:0];
      OFS_RXRD_H: v = r.rxrd[15:8];
      OFS_RXRD_L: v = r.rxrd[7:0];
      default:    v = 8'h00;
    endcase
    return v;
  endfunction

  function automatic sock_regs_t sock_wr(input sock_regs_t r, input logic [7:0] ofs,
                                         input logic [7:0] v);
    sock_regs_t o;
    o = r;
    case (ofs)
      OFS_MODE:   o.mode = v;
      OFS_CMD:    o.cmd = v;
      OFS_STAT:   o.stat = v;
      OFS_TXFR_H: o.txfree[15:8] = v;
      OFS_TXFR_L: o.txfree[7:0] = v;
      OFS_TXRD_H: o.txrd[15:8] = v;
      OFS_TXRD_L: o.txrd[7:0] = v;
      OFS_TXWR_H: o.txwr[15:8] = v;
      OFS_TXWR_L: o.txwr[7:0] = v;
      OFS_RXSZ_H: o.rxsize[15:8] = v;
      OFS_RXSZ_L: o.rxsize[7:0] = v;
      OFS_RXRD_H: o.rxrd[15:8] = v;
      OFS_RXRD_L: o.rxrd[7:0] = v;
      default:    o = r;
    endcase
    return o;
  endfunction

endpackage

FILE: src/esrb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module esrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: src/esrb_ctrl.sv
// Controller state machine: store clear sweep, item execute, read wait, result hold.
// Depends on esrb_pkg.
module esrb_ctrl import esrb_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  ctrl_stat_t stat,
  output ctrl_cmd_t  cmd
);
  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_EXEC  = 5'b00100,
    S_RDW   = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (stat.clear_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        state_nxt = stat.need_read ? S_RDW : S_OUT;
      end
      S_RDW: begin
        cmd.capture = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_nxt = stat.clr_pend ? S_CLEAR : S_IDLE;
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear_step |-> !in_ready && !out_valid) else $error("clear overlaps traffic");
  a_exec_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> cmd.exec) else $error("load not followed by execute");
  a_capture_order: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> out_valid) else $error("capture not followed by result");
endmodule

FILE: src/esrb_datapath.sv
// Datapath: item registers, mode and socket register flops, store RAM, event logic.
// Depends on esrb_pkg and esrb_ram.
module esrb_datapath import esrb_pkg::*; #(
  parameter int STORE_DEPTH = DefStoreDepth,
  parameter int SOCKETS     = DefSockets,
  parameter int RING_BYTES  = DefRingBytes
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [2:0] in_command,
  input  logic [1:0] in_port,
  input  logic [7:0] in_data,
  input  logic [1:0] in_socket,
  input  ctrl_cmd_t  cmd,
  output ctrl_stat_t stat,
  output logic [7:0] out_read_data
);
  localparam int AW = $clog2(STORE_DEPTH);
  localparam int RW = $clog2(RING_BYTES);
  localparam logic [16:0] DEPTH17 = 17'(STORE_DEPTH);
  localparam logic [15:0] RING16  = 16'(RING_BYTES);
  localparam logic [2:0]  NSOCK   = 3'(SOCKETS);

  // store index: address modulo store depth, value below twice the depth
  function automatic logic [15:0] store_idx(input logic [16:0] a);
    return (a >= DEPTH17) ? 16'(a - DEPTH17) : a[15:0];
  endfunction

  function automatic logic mirror_hit(input logic [15:0] i);
    return (i[15:10] == SOCK_REGION) && ({1'b0, i[9:8]} < NSOCK) && sock_hit(i[7:0]);
  endfunction

  logic [2:0]  cmd_r;
  logic [1:0]  port_r;
  logic [7:0]  data_r;
  logic [1:0]  sock_r;
  logic [15:0] addr_r, addr_nxt;
  logic [7:0]  mode_r, mode_nxt;
  sock_regs_t  sregs_r [MaxSockets];
  sock_regs_t  sregs_nxt [MaxSockets];
  logic        open_r [MaxSockets];
  logic        open_nxt [MaxSockets];
  logic [15:0] wp_r [MaxSockets];
  logic [15:0] wp_nxt [MaxSockets];
  logic [RW-1:0] ofs_r [MaxSockets];
  logic [RW-1:0] ofs_nxt [MaxSockets];
  logic [7:0]  result_r, result_nxt;
  logic [AW-1:0] clr_cnt_r;
  logic        clr_pend_r, clr_pend_nxt;

  logic [15:0] i_data, ring_i, used, rdsz;
  logic [16:0] ring_a;
  logic        evt_ok, rx_ok, soft_rst, swr_en, ram_we;
  logic [15:0] swr_i;
  logic [7:0]  swr_v, st_cur, ram_rdata;
  logic [1:0]  cs;

  // store RAM
  esrb_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_ram (
    .clk   (clk),
    .we    (cmd.clear_step || ram_we),
    .waddr (cmd.clear_step ? clr_cnt_r : AW'(swr_i)),
    .wdata (cmd.clear_step ? 8'h00 : swr_v),
    .raddr (AW'(i_data)),
    .rdata (ram_rdata)
  );

  // address and event decode
  assign i_data = store_idx({1'b0, addr_r});
  assign ring_a = 17'(RING_BASE) + 17'(sock_r) * 17'(RING_BYTES) + 17'(ofs_r[sock_r]);
  assign ring_i = store_idx(ring_a);
  assign evt_ok = ({1'b0, sock_r} < NSOCK) && open_r[sock_r];
  assign st_cur = sregs_r[sock_r].stat;
  assign used   = wp_r[sock_r] - sregs_r[sock_r].rxrd;
  assign rx_ok  = evt_ok && (st_cur == ST_EST || st_cur == ST_UDP) && (used != RING16);

  assign stat.need_read = (cmd_r == CMD_BUS_RD) && (port_r == PORT_DATA) &&
                          (i_data != 16'h0000) && !mirror_hit(i_data);
  assign stat.clr_pend   = clr_pend_r;
  assign stat.clear_done = cmd.clear_step && (clr_cnt_r == AW'(STORE_DEPTH - 1));
  assign out_read_data   = result_r;

  // store byte write request of the item
  always_comb begin
    swr_en = 1'b0;
    swr_i = 16'h0000;
    swr_v = data_r;
    soft_rst = 1'b0;
    if (cmd.exec) begin
      case (cmd_r)
        CMD_BUS_WR: begin
          if (port_r == PORT_MODE) begin
            if (data_r[7]) soft_rst = 1'b1;
            else swr_en = 1'b1;
          end else if (port_r == PORT_DATA) begin
            if (i_data == 16'h0000 && data_r[7]) begin
              soft_rst = 1'b1;
            end else begin
              swr_en = 1'b1;
              swr_i = i_data;
            end
          end
        end
        CMD_RX_BYTE: begin
          if (rx_ok) begin
            swr_en = 1'b1;
            swr_i = ring_i;
          end
        end
        default: swr_en = 1'b0;
      endcase
    end
  end

  // state update: store write first, then command and event effects
  always_comb begin
    addr_nxt = addr_r;
    mode_nxt = mode_r;
    sregs_nxt = sregs_r;
    open_nxt = open_r;
    wp_nxt = wp_r;
    ofs_nxt = ofs_r;
    result_nxt = result_r;
    clr_pend_nxt = clr_pend_r;
    ram_we = 1'b0;
    cs = swr_i[9:8];
    rdsz = 16'h0000;
    if (stat.clear_done) clr_pend_nxt = 1'b0;
    if (cmd.capture) result_nxt = ram_rdata;
    if (cmd.exec) begin
      result_nxt = 8'h00;
      if (soft_rst) begin
        mode_nxt = MODE_RESET;
        clr_pend_nxt = 1'b1;
        for (int k = 0; k < MaxSockets; k++) begin
          sregs_nxt[k] = '0;
          open_nxt[k] = 1'b0;
          wp_nxt[k] = 16'h0000;
          ofs_nxt[k] = '0;
        end
      end else if (swr_en) begin
        if (swr_i == 16'h0000) mode_nxt = swr_v;
        else if (mirror_hit(swr_i)) sregs_nxt[cs] = sock_wr(sregs_nxt[cs], swr_i[7:0], swr_v);
        else ram_we = 1'b1;
      end

      // socket command on a nonzero bus write to a command register
      if (cmd_r == CMD_BUS_WR && swr_en && mirror_hit(swr_i) &&
          swr_i[7:0] == OFS_CMD && swr_v != 8'h00) begin
        case (swr_v)
          SC_OPEN: begin
            open_nxt[cs] = 1'b1;
            sregs_nxt[cs].stat = (sregs_nxt[cs].mode[3:0] == 4'd1) ? ST_INIT : ST_UDP;
            sregs_nxt[cs].txfree = RING16;
            sregs_nxt[cs].txwr = 16'h0000;
            sregs_nxt[cs].txrd = 16'h0000;
            sregs_nxt[cs].rxsize = 16'h0000;
            sregs_nxt[cs].rxrd = 16'h0000;
            wp_nxt[cs] = 16'h0000;
            ofs_nxt[cs] = '0;
          end
          SC_CONNECT: sregs_nxt[cs].stat = open_r[cs] ? ST_SYNSENT : ST_CLOSED;
          SC_SEND: begin
            sregs_nxt[cs].txrd = sregs_nxt[cs].txwr;
            sregs_nxt[cs].txfree = RING16;
          end
          SC_RECV: sregs_nxt[cs].rxsize = wp_r[cs] - sregs_nxt[cs].rxrd;
          SC_DISCON, SC_CLOSE: begin
            open_nxt[cs] = 1'b0;
            sregs_nxt[cs].stat = ST_CLOSED;
            sregs_nxt[cs].rxsize = 16'h0000;
            sregs_nxt[cs].txfree = 16'h0000;
            wp_nxt[cs] = 16'h0000;
            ofs_nxt[cs] = '0;
          end
          default: sregs_nxt[cs].cmd = 8'h00;
        endcase
        sregs_nxt[cs].cmd = 8'h00;
      end

      // network events
      if (evt_ok) begin
        case (cmd_r)
          CMD_CONN_OK: begin
            if (st_cur == ST_SYNSENT) begin
              sregs_nxt[sock_r].stat = ST_EST;
              sregs_nxt[sock_r].txfree = RING16;
            end
          end
          CMD_CONN_NG: begin
            if (st_cur == ST_SYNSENT) begin
              sregs_nxt[sock_r].stat = ST_CLOSED;
              open_nxt[sock_r] = 1'b0;
            end
          end
          CMD_RX_BYTE: begin
            if (rx_ok) begin
              wp_nxt[sock_r] = wp_r[sock_r] + 16'd1;
              ofs_nxt[sock_r] = (ofs_r[sock_r] == RW'(RING_BYTES - 1)) ? '0
                                : ofs_r[sock_r] + RW'(1);
              rdsz = wp_r[sock_r] + 16'd1 - sregs_r[sock_r].rxrd;
              sregs_nxt[sock_r].rxsize = rdsz;
            end
          end
          CMD_PEER_CL: begin
            if ((st_cur == ST_EST || st_cur == ST_UDP) &&
                sregs_r[sock_r].mode[3:0] != 4'd2) begin
              sregs_nxt[sock_r].stat = ST_CLOSEWAIT;
              open_nxt[sock_r] = 1'b0;
            end
          end
          default: rdsz = 16'h0000;
        endcase
      end

      // bus address and reads
      case (cmd_r)
        CMD_BUS_RD: begin
          case (port_r)
            PORT_MODE: result_nxt = mode_r;
            PORT_ADDH: result_nxt = addr_r[15:8];
            PORT_ADDL: result_nxt = addr_r[7:0];
            default: begin
              if (i_data == 16'h0000) result_nxt = mode_r;
              else if (mirror_hit(i_data)) result_nxt = sock_rd(sregs_r[i_data[9:8]], i_data[7:0]);
              if (mode_r[1]) addr_nxt = addr_r + 16'd1;
            end
          endcase
        end
        CMD_BUS_WR: begin
          case (port_r)
            PORT_ADDH: addr_nxt = {data_r, addr_r[7:0]};
            PORT_ADDL: addr_nxt = {addr_r[15:8], data_r};
            PORT_DATA: if (mode_nxt[1]) addr_nxt = addr_r + 16'd1;
            default:   addr_nxt = addr_r;
          endcase
        end
        default: addr_nxt = addr_r;
      endcase
    end
  end

  // item and result registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r <= in_command;
      port_r <= in_port;
      data_r <= in_data;
      sock_r <= in_socket;
    end
    result_r <= result_nxt;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r <= 16'h0000;
      mode_r <= MODE_RESET;
      clr_pend_r <= 1'b0;
      clr_cnt_r <= '0;
      for (int k = 0; k < MaxSockets; k++) begin
        sregs_r[k] <= '0;
        open_r[k] <= 1'b0;
        wp_r[k] <= 16'h0000;
        ofs_r[k] <= '0;
      end
    end else begin
      addr_r <= addr_nxt;
      mode_r <= mode_nxt;
      clr_pend_r <= clr_pend_nxt;
      clr_cnt_r <= cmd.clear_step ? clr_cnt_r + AW'(1) : '0;
      sregs_r <= sregs_nxt;
      open_r <= open_nxt;
      wp_r <= wp_nxt;
      ofs_r <= ofs_nxt;
    end
  end

  a_soft_rst_mode: assert property (@(posedge clk) disable iff (!rst_n)
    soft_rst |=> mode_r == MODE_RESET && clr_pend_r) else $error("soft reset lost");
  a_ring_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && cmd_r == CMD_RX_BYTE && rx_ok) |=> wp_r[sock_r] == $past(wp_r[sock_r]) + 16'd1)
    else $error("rx pointer not advanced");
  a_no_ram_write_in_read: assert property (@(posedge clk) disable iff (!rst_n)
    stat.need_read && cmd.exec |-> !ram_we) else $error("write during read");
endmodule

FILE: src/ethernet_socket_register_bank_core.sv
// Top level of the socket register bank: controller plus datapath.
// Depends on esrb_pkg, esrb_ctrl, esrb_datapath (and esrb_ram through it).
//
// One item is handled at a time. A bus read of the store RAM passes through the states
// accept, execute, RAM read wait and result; every other item goes from execute straight
// to result. The store RAM's single registered read port sets the extra wait. After reset
// and after every soft reset the store RAM is cleared one byte per cycle, during which no
// item is accepted. Mode, socket registers and pointers live in flops and are cleared at
// once.
module ethernet_socket_register_bank_core import esrb_pkg::*; #(
  parameter int STORE_DEPTH = DefStoreDepth,
  parameter int SOCKETS     = DefSockets,
  parameter int RING_BYTES  = DefRingBytes
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] in_command,
  input  logic [1:0] in_port,
  input  logic [7:0] in_data,
  input  logic [1:0] in_socket,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_read_data
);
  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;

  // sequencing
  esrb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // registers, store and event logic
  esrb_datapath #(
    .STORE_DEPTH (STORE_DEPTH),
    .SOCKETS     (SOCKETS),
    .RING_BYTES  (RING_BYTES)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_command    (in_command),
    .in_port       (in_port),
    .in_data       (in_data),
    .in_socket     (in_socket),
    .cmd           (cmd),
    .stat          (stat),
    .out_read_data (out_read_data)
  );

  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("input and output open together");
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("second item taken");
  a_out_once: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready |=> !out_valid) else $error("result repeated");
endmodule
